// ===== src/swept_box_contact_resolve_macros.svh =====
// Assertion macros shared by the checker of the swept box contact resolver
`ifndef SWEPT_BOX_CONTACT_RESOLVE_MACROS_SVH
`define SWEPT_BOX_CONTACT_RESOLVE_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger
`define SBCR_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("sbcr check failed");

// Check a condition that must hold in the cycle after its trigger
`define SBCR_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) (trig) |=> (cond)) \
    else $error("sbcr check failed");

`endif

// ===== src/sbcr_pkg.sv =====
// Types, constants and helper functions of the swept box contact resolver
package sbcr_pkg;

  localparam int CoordW = 20;
  localparam int StepW  = 16;
  localparam int TimeW  = 17;
  localparam int FracW  = 16;
  localparam int EdgeW  = 23;
  localparam int RemW   = 17;
  localparam int Lanes  = 4;
  localparam int QueueDepthDefault = 2;
  localparam logic [TimeW-1:0] TimeOne = 17'h10000;

  // Classified transaction handed from the front to the back
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] mx;
    logic signed [CoordW-1:0] my;
    logic signed [StepW-1:0]  dx;
    logic signed [StepW-1:0]  dy;
    logic [Lanes-1:0]         tv;
    logic [Lanes-1:0][RemW-1:0] rem;
    logic [StepW-1:0]         adx;
    logic [StepW-1:0]         ady;
  } sbcr_item_t;

  // One divider stage of the back
  typedef struct packed {
    sbcr_item_t               it;
    logic [Lanes-1:0][FracW-1:0] quo;
  } sbcr_stage_t;

  // Qualify a face time n/d and return {valid, starting remainder}
  function automatic logic [RemW:0] face_init(input logic signed [EdgeW-1:0] n,
                                              input logic signed [StepW-1:0] d);
    logic signed [EdgeW-1:0] an;
    logic signed [EdgeW-1:0] ad;
    logic                    ok;
    an = n[EdgeW-1] ? -n : n;
    ad = d[StepW-1] ? -EdgeW'(d) : EdgeW'(d);
    ok = (d != '0) && ((n == '0) ||
         (((n > 0) == (d > 0)) && (an < ad)));
    face_init = ok ? {1'b1, an[RemW-1:0]} : '0;
  endfunction

  // Advance every lane's restoring division by one quotient bit
  function automatic sbcr_stage_t div_step(input sbcr_stage_t s);
    sbcr_stage_t r;
    logic [RemW-1:0] r2;
    logic [RemW-1:0] den;
    r = s;
    for (int i = 0; i < Lanes; i++) begin
      r2  = {s.it.rem[i][RemW-2:0], 1'b0};
      den = (i < 2) ? RemW'(s.it.adx) : RemW'(s.it.ady);
      if (r2 >= den) begin
        r.it.rem[i] = r2 - den;
        r.quo[i]    = {s.quo[i][FracW-2:0], 1'b1};
      end else begin
        r.it.rem[i] = r2;
        r.quo[i]    = {s.quo[i][FracW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/swept_box_contact_resolve.sv =====
// Top level of the swept box contact resolver
//
// Moves an axis-aligned box by one step and stops it at the first face of a
// static box it runs into. Each box pair is independent; no state is kept.
// Input: a transaction is taken on a rising edge where start is high and busy
// is low. All ten box fields are sampled at that edge.
// Output: done pulses for one cycle with hit, new_x, new_y and hit_time; the
// receiver takes it at the end of that cycle and cannot push back.
// Path: front register, queue slot, divider load, the 16-stage pipelined
// restoring divider (one quotient bit a stage, four face times side by side),
// then the min, multiply and output stages.
// Throughput: one pair per cycle. The front registers and classifies a pair,
// a short queue feeds the back, and the back always advances, so busy stays
// low in normal operation.
// Reset: clears the front, queue and pipeline valid bits; no done pulse
// follows until a new transaction is accepted.
module swept_box_contact_resolve #(
  parameter int QueueDepth = sbcr_pkg::QueueDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sbcr_pkg::CoordW-1:0] moving_x,
  input  logic signed [sbcr_pkg::CoordW-1:0] moving_y,
  input  logic [15:0]                       moving_half_width,
  input  logic [15:0]                       moving_half_height,
  input  logic signed [sbcr_pkg::StepW-1:0] step_dx,
  input  logic signed [sbcr_pkg::StepW-1:0] step_dy,
  input  logic signed [sbcr_pkg::CoordW-1:0] wall_x,
  input  logic signed [sbcr_pkg::CoordW-1:0] wall_y,
  input  logic [15:0]                       wall_half_width,
  input  logic [15:0]                       wall_half_height,
  output logic                              done,
  output logic                              hit,
  output logic signed [sbcr_pkg::CoordW-1:0] new_x,
  output logic signed [sbcr_pkg::CoordW-1:0] new_y,
  output logic [sbcr_pkg::TimeW-1:0]        hit_time
);

  logic                 push, full, empty;
  sbcr_pkg::sbcr_item_t fitem, qitem;

  sbcr_front u_front (
    .clk, .rst, .start, .busy,
    .moving_x, .moving_y, .moving_half_width, .moving_half_height,
    .step_dx, .step_dy, .wall_x, .wall_y, .wall_half_width, .wall_half_height,
    .push, .item(fitem), .full
  );

  sbcr_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push, .din(fitem), .full,
    .pop(!empty), .empty, .dout(qitem)
  );

  sbcr_back u_back (
    .clk, .rst, .load(!empty), .item(qitem),
    .done, .hit, .new_x, .new_y, .hit_time
  );

endmodule

// ===== src/sbcr_front.sv =====
// Front: accept a box pair, run the overlap test and set up the face divisions
module sbcr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sbcr_pkg::CoordW-1:0] moving_x,
  input  logic signed [sbcr_pkg::CoordW-1:0] moving_y,
  input  logic [15:0]                       moving_half_width,
  input  logic [15:0]                       moving_half_height,
  input  logic signed [sbcr_pkg::StepW-1:0] step_dx,
  input  logic signed [sbcr_pkg::StepW-1:0] step_dy,
  input  logic signed [sbcr_pkg::CoordW-1:0] wall_x,
  input  logic signed [sbcr_pkg::CoordW-1:0] wall_y,
  input  logic [15:0]                       wall_half_width,
  input  logic [15:0]                       wall_half_height,
  output logic                              push,
  output sbcr_pkg::sbcr_item_t              item,
  input  logic                              full
);

  localparam int W = sbcr_pkg::EdgeW;

  logic signed [W-1:0] mx, my, mhw, mhh, dx, dy, wx, wy, whw, whh;
  logic signed [W-1:0] wl, wr, wt, wb, fx, fy;
  logic [sbcr_pkg::RemW:0] f0, f1, f2, f3;
  logic                 sep, accept, fvalid;
  sbcr_pkg::sbcr_item_t cls;

  // Extend all fields to a common exact width
  always_comb begin
    mx  = W'(moving_x);
    my  = W'(moving_y);
    mhw = W'(moving_half_width);
    mhh = W'(moving_half_height);
    dx  = W'(step_dx);
    dy  = W'(step_dy);
    wx  = W'(wall_x);
    wy  = W'(wall_y);
    whw = W'(wall_half_width);
    whh = W'(wall_half_height);
    wl  = wx - whw;
    wr  = wx + whw;
    wt  = wy - whh;
    wb  = wy + whh;
    fx  = mx + dx;
    fy  = my + dy;
  end

  // Classify: separation of the shifted box, then the four face times
  always_comb begin
    sep = (wr <= fx - mhw) || (fx + mhw <= wl) || (wb <= fy - mhh) || (fy + mhh <= wt);
    f0  = sbcr_pkg::face_init(wr - (mx - mhw), step_dx);
    f1  = sbcr_pkg::face_init(wl - (mx + mhw), step_dx);
    f2  = sbcr_pkg::face_init(wb - (my - mhh), step_dy);
    f3  = sbcr_pkg::face_init(wt - (my + mhh), step_dy);
    cls.hit    = !sep;
    cls.mx     = moving_x;
    cls.my     = moving_y;
    cls.dx     = step_dx;
    cls.dy     = step_dy;
    cls.tv     = {f3[sbcr_pkg::RemW], f2[sbcr_pkg::RemW],
                  f1[sbcr_pkg::RemW], f0[sbcr_pkg::RemW]};
    cls.rem[0] = f0[sbcr_pkg::RemW-1:0];
    cls.rem[1] = f1[sbcr_pkg::RemW-1:0];
    cls.rem[2] = f2[sbcr_pkg::RemW-1:0];
    cls.rem[3] = f3[sbcr_pkg::RemW-1:0];
    cls.adx    = step_dx[sbcr_pkg::StepW-1] ? 16'(-step_dx) : 16'(step_dx);
    cls.ady    = step_dy[sbcr_pkg::StepW-1] ? 16'(-step_dy) : 16'(step_dy);
  end

  assign busy   = fvalid && full;
  assign accept = start && !busy;
  assign push   = fvalid && !full;

  // Hold the classified transaction until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cls;
    end
  end

endmodule

// ===== src/sbcr_queue.sv =====
// Short queue between the front and the back
module sbcr_queue #(
  parameter int Depth = sbcr_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbcr_pkg::sbcr_item_t din,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output sbcr_pkg::sbcr_item_t dout
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  sbcr_pkg::sbcr_item_t entries [Depth];
  logic [AddrW-1:0]  wptr, rptr;
  logic [CountW-1:0] count;

  assign full  = (count == CountW'(Depth));
  assign empty = (count == '0);
  assign dout  = entries[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AddrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AddrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

endmodule

// ===== src/sbcr_back.sv =====
// Back: pipelined face-time division, earliest time, scaled step and saturation
module sbcr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  sbcr_pkg::sbcr_item_t              item,
  output logic                              done,
  output logic                              hit,
  output logic signed [sbcr_pkg::CoordW-1:0] new_x,
  output logic signed [sbcr_pkg::CoordW-1:0] new_y,
  output logic [sbcr_pkg::TimeW-1:0]        hit_time
);

  localparam int Steps = sbcr_pkg::FracW;
  localparam int CW    = sbcr_pkg::CoordW;
  localparam int PW    = sbcr_pkg::StepW + sbcr_pkg::TimeW + 1;
  localparam int FracW_HI = 16 + 17;

  sbcr_pkg::sbcr_stage_t st [Steps+1];
  logic [Steps:0]        sv;

  // Load a transaction from the queue into the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= load;
    end
  end

  always_ff @(posedge clk) begin
    st[0].it  <= item;
    st[0].quo <= '0;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= Steps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else begin
        sv[k] <= sv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      st[k] <= sbcr_pkg::div_step(st[k-1]);
    end
  end

  // Pick the earliest valid face time
  logic [sbcr_pkg::TimeW-1:0] best;
  always_comb begin
    best = sbcr_pkg::TimeOne;
    for (int i = 0; i < sbcr_pkg::Lanes; i++) begin
      if (st[Steps].it.tv[i] && (sbcr_pkg::TimeW'(st[Steps].quo[i]) < best)) begin
        best = sbcr_pkg::TimeW'(st[Steps].quo[i]);
      end
    end
    if (!st[Steps].it.hit) begin
      best = '0;
    end
  end

  logic                            mv, mhit;
  logic signed [CW-1:0]            mmx, mmy;
  logic signed [sbcr_pkg::StepW-1:0] mdx, mdy;
  logic [sbcr_pkg::TimeW-1:0]      mbest;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= sv[Steps];
    end
  end

  always_ff @(posedge clk) begin
    mhit  <= st[Steps].it.hit;
    mmx   <= st[Steps].it.mx;
    mmy   <= st[Steps].it.my;
    mdx   <= st[Steps].it.dx;
    mdy   <= st[Steps].it.dy;
    mbest <= best;
  end

  // Scale each displacement by the chosen time
  logic                       pv, phit;
  logic signed [CW-1:0]       pmx, pmy;
  logic signed [PW-1:0]       px, py;
  logic [sbcr_pkg::TimeW-1:0] pbest;
  logic signed [sbcr_pkg::TimeW:0] tsg;

  assign tsg = signed'({1'b0, mbest});

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= mv;
    end
  end

  always_ff @(posedge clk) begin
    phit  <= mhit;
    pmx   <= mmx;
    pmy   <= mmy;
    pbest <= mbest;
    px    <= PW'(mdx) * PW'(tsg);
    py    <= PW'(mdy) * PW'(tsg);
  end

  // Truncate toward zero, add and saturate
  logic [PW-1:0]         magx, magy;
  logic signed [17:0]    scx, scy;
  logic signed [CW:0]    sumx, sumy;
  logic signed [CW-1:0]  satx, saty;

  always_comb begin
    magx = px[PW-1] ? PW'(-px) : PW'(px);
    magy = py[PW-1] ? PW'(-py) : PW'(py);
    scx  = px[PW-1] ? -signed'(magx[FracW_HI:16]) : signed'(magx[FracW_HI:16]);
    scy  = py[PW-1] ? -signed'(magy[FracW_HI:16]) : signed'(magy[FracW_HI:16]);
    sumx = (CW+1)'(pmx) + (CW+1)'(scx);
    sumy = (CW+1)'(pmy) + (CW+1)'(scy);
    if (sumx > (CW+1)'(2**(CW-1) - 1)) begin
      satx = {1'b0, {(CW-1){1'b1}}};
    end else if (sumx < -(CW+1)'(2**(CW-1))) begin
      satx = {1'b1, {(CW-1){1'b0}}};
    end else begin
      satx = sumx[CW-1:0];
    end
    if (sumy > (CW+1)'(2**(CW-1) - 1)) begin
      saty = {1'b0, {(CW-1){1'b1}}};
    end else if (sumy < -(CW+1)'(2**(CW-1))) begin
      saty = {1'b1, {(CW-1){1'b0}}};
    end else begin
      saty = sumy[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv;
    end
  end

  always_ff @(posedge clk) begin
    hit      <= phit;
    new_x    <= phit ? satx : pmx;
    new_y    <= phit ? saty : pmy;
    hit_time <= pbest;
  end

endmodule

// ===== src/sbcr_checker.sv =====
// Port-level checks of the swept box contact resolver and their binding
`include "swept_box_contact_resolve_macros.svh"

module sbcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [16:0] hit_time
);

  `SBCR_ASSERT_NOW(a_miss_zero_time, done && !hit, hit_time == 17'd0)
  `SBCR_ASSERT_NOW(a_time_range, done && hit, hit_time <= 17'h10000)
  `SBCR_ASSERT_NEXT(a_quiet_after_reset, rst, !done && !busy)

endmodule

bind swept_box_contact_resolve sbcr_checker u_sbcr_checker (.*);
